FILE: design/sutt_pkg.sv
// Shared types and constants for the sorted unique time table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sutt_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int TIME_W  = 64;
   localparam int TOL_W   = 32;
   localparam int FIELD_W = 9;

   // Item modes
   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [TIME_W-1:0] time_value;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] floor_index;
      logic [FIELD_W-1:0]        entry_count;
      logic                      inserted;
      logic                      table_full;
   } rsp_type;

   // What one cell hands to its right neighbor
   typedef struct packed {
      logic                     valid;
      logic                     le_now;
      logic                     le_ff;
      logic signed [TIME_W-1:0] entry;
   } link_type;

   // Registered compare results of one cell
   typedef struct packed {
      logic le;
      logic near;
   } flags_type;

   // Control from the sequencer to every cell
   typedef struct packed {
      logic capture;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: design/sutt_cell.sv
// One cell of the sorted chain: holds one entry and its valid bit.
// Depends on sutt_pkg.
`default_nettype none

module sutt_cell (
   input  wire                               clock,
   input  wire                               reset,
   input  sutt_pkg::cell_ctrl_type           ctrl,
   input  wire signed [sutt_pkg::TIME_W-1:0] t,
   input  wire [sutt_pkg::TOL_W-1:0]         tol,
   input  sutt_pkg::link_type                left,
   input  wire                               right_le_now,
   output sutt_pkg::link_type                link,
   output sutt_pkg::flags_type               flags
);
   import sutt_pkg::*;

   logic                     valid_ff, valid_in;
   logic                     le_ff, le_in;
   logic                     near_ff, near_in;
   logic signed [TIME_W-1:0] entry_ff, entry_in;
   logic [TIME_W:0]          diff;
   logic [TIME_W:0]          abs_diff;
   logic                     le_now;
   logic                     tol_hit;

   // Compare the held entry against the item time with one subtract
   always_comb begin
      diff     = {t[TIME_W-1], t} - {entry_ff[TIME_W-1], entry_ff};
      abs_diff = diff[TIME_W] ? (~diff + {{TIME_W{1'b0}}, 1'b1}) : diff;
      tol_hit  = abs_diff <= {{(TIME_W + 1 - TOL_W){1'b0}}, tol};
      le_now   = valid_ff && !diff[TIME_W];
      // near the floor entry, or near the first entry above the time
      near_in  = (le_now && !right_le_now && tol_hit) ||
                 (valid_ff && !le_now && left.le_now && tol_hit);
      le_in    = ctrl.capture ? le_now : le_ff;
      if (!ctrl.capture) begin
         near_in = near_ff;
      end
   end

   // Shift right on insert: cells above the floor take the left entry,
   // the cell at the insert point takes the new time
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.shift && !le_ff) begin
         entry_in = left.le_ff ? t : left.entry;
         valid_in = valid_ff | left.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         le_ff    <= 1'b0;
         near_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         le_ff    <= le_in;
         near_ff  <= near_in;
      end
   end

   // Hold entry payload without reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.valid  = valid_ff;
   assign link.le_now = le_now;
   assign link.le_ff  = le_ff;
   assign link.entry  = entry_ff;
   assign flags.le    = le_ff;
   assign flags.near  = near_ff;

endmodule

`default_nettype wire

FILE: design/sutt_floor_enc.sv
// Reduce the registered cell flags to the floor index and a near-match flag.
// Depends on sutt_pkg.
`default_nettype none

module sutt_floor_enc (
   input  sutt_pkg::flags_type              flags [sutt_pkg::TABLE_DEPTH],
   output logic signed [sutt_pkg::IDX_W:0]  floor_wide,
   output logic                             near_any
);
   import sutt_pkg::*;

   logic [TABLE_DEPTH-1:0] le_vec;
   logic [TABLE_DEPTH-1:0] le_next;
   logic [TABLE_DEPTH-1:0] bound;
   logic [IDX_W-1:0]       idx;

   // Gather the le prefix and mark its last cell
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         le_vec[i] = flags[i].le;
      end
      le_next = {1'b0, le_vec[TABLE_DEPTH-1:1]};
      bound   = le_vec & ~le_next;
   end

   // Encode the one-hot boundary and fold the near flags
   always_comb begin
      idx      = '0;
      near_any = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         idx      = idx | (bound[i] ? IDX_W'(i) : '0);
         near_any = near_any | flags[i].near;
      end
      floor_wide = le_vec[0] ? signed'({1'b0, idx}) : '1;
   end

endmodule

`default_nettype wire

FILE: design/sorted_unique_time_table_core.sv
// Top level of the sorted unique time table: cell chain plus sequencer.
// Depends on sutt_pkg, sutt_cell and sutt_floor_enc.
// The result strobe rises after the compare and update states that follow the start transfer.
// A new item is taken only when idle: busy stays high through the compare and update states.
// Reset clears the valid bits of all cells, the entry count and tolerance.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module sorted_unique_time_table_core (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  sutt_pkg::req_type               req_data,
   output logic                            rsp_strobe,
   output sutt_pkg::rsp_type               rsp_data,
   input  wire                             csr_wr_en,
   input  wire [sutt_pkg::TOL_W-1:0]       csr_wr_data
);
   import sutt_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CMP,
      PH_UPD
   } phase_type;

   phase_type              state_ff;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_ff;
   logic [COUNT_W-1:0]     count_ff, count_in;
   req_type                req_ff;
   logic [TOL_W-1:0]       tol_ff;

   link_type               links [TABLE_DEPTH+1];
   flags_type              flags [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_vec;
   cell_ctrl_type          ctrl;
   logic signed [IDX_W:0]  floor_wide;
   logic                   near_any;
   logic                   accept;
   logic                   full;
   logic                   do_ins;
   logic                   do_drop;

   assign busy   = state_ff != PH_IDLE;
   assign accept = start && !busy;

   // Decide the insert in the update cycle
   always_comb begin
      full         = count_ff == COUNT_W'(TABLE_DEPTH);
      do_ins       = (req_ff.mode == MODE_INSERT) && !near_any && !full;
      do_drop      = (req_ff.mode == MODE_INSERT) && !near_any && full;
      count_in     = count_ff + {{(COUNT_W-1){1'b0}}, do_ins};
      ctrl.capture = state_ff == PH_CMP;
      ctrl.shift   = (state_ff == PH_UPD) && do_ins;
   end

   // Left edge of the chain acts as an always-below entry
   assign links[0].valid  = 1'b1;
   assign links[0].le_now = 1'b1;
   assign links[0].le_ff  = 1'b1;
   assign links[0].entry  = '0;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic right_le;
      if (g < TABLE_DEPTH - 1) begin : g_mid
         assign right_le = links[g+2].le_now;
      end else begin : g_end
         assign right_le = 1'b0;
      end
      sutt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .t            (req_ff.time_value),
         .tol          (tol_ff),
         .left         (links[g]),
         .right_le_now (right_le),
         .link         (links[g+1]),
         .flags        (flags[g])
      );
      assign valid_vec[g] = links[g+1].valid;
   end

   sutt_floor_enc u_enc (
      .flags      (flags),
      .floor_wide (floor_wide),
      .near_any   (near_any)
   );

   // Write the tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // Hold the accepted item through compare and update
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // Advance the sequencer and register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PH_IDLE;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
         rsp_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            PH_IDLE: begin
               if (accept) begin
                  state_ff <= PH_CMP;
               end
            end
            PH_CMP: begin
               state_ff <= PH_UPD;
            end
            PH_UPD: begin
               state_ff             <= PH_IDLE;
               count_ff             <= count_in;
               rsp_strobe_ff        <= 1'b1;
               rsp_ff.floor_index   <= FIELD_W'(floor_wide);
               rsp_ff.entry_count   <= FIELD_W'(count_in);
               rsp_ff.inserted      <= do_ins;
               rsp_ff.table_full    <= do_drop;
            end
            default: begin
               state_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("cell valid bits disagree with entry count");

   a_ins_drop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.inserted && rsp_data.table_full))
      else $error("insert both added and dropped");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.table_full |-> count_ff == COUNT_W'(TABLE_DEPTH))
      else $error("insert dropped while table has room");

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == PH_UPD)
      else $error("result strobe without update cycle");

   a_insert_grows_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == PH_UPD && do_ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance the entry count");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for sorted_unique_time_table_core: inserts and floor lookups.
// Depends on sutt_pkg and the core; every result is checked against a local table model.
`timescale 1ns / 1ps

module testbench;
   import sutt_pkg::*;

   localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam int CYCLE_LIMIT = 400000;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [TOL_W-1:0]  csr_wr_data;

   // Local copy of the table and its register
   logic signed [TIME_W-1:0] held_times [TABLE_DEPTH];
   int                       held_count;
   logic [TOL_W-1:0]         tolerance_now;

   rsp_type due_outcomes[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      idle_pct = 0;

   sorted_unique_time_table_core uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Distance between two times, exact in 64 unsigned bits
   function automatic logic [TIME_W-1:0] time_gap(input logic signed [TIME_W-1:0] a,
                                                  input logic signed [TIME_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Run one item against the table; return the result it must produce
   function automatic rsp_type apply_to_table(input req_type item);
      rsp_type outcome;
      int      floor_pos;
      int      slot;
      bit      is_near;
      floor_pos = -1;
      for (int i = 0; i < held_count; i++) begin
         if (held_times[i] <= item.time_value) floor_pos = i;
         else break;
      end
      outcome.inserted   = 1'b0;
      outcome.table_full = 1'b0;
      if (item.mode == MODE_INSERT) begin
         slot = floor_pos + 1;
         is_near = 1'b0;
         if (floor_pos >= 0 &&
             time_gap(held_times[floor_pos], item.time_value) <= {32'd0, tolerance_now})
            is_near = 1'b1;
         if (slot < held_count &&
             time_gap(held_times[slot], item.time_value) <= {32'd0, tolerance_now})
            is_near = 1'b1;
         if (!is_near) begin
            if (held_count >= TABLE_DEPTH) begin
               outcome.table_full = 1'b1;
            end else begin
               for (int i = held_count; i > slot; i--) held_times[i] = held_times[i-1];
               held_times[slot] = item.time_value;
               held_count++;
               outcome.inserted = 1'b1;
            end
         end
      end
      outcome.floor_index = 9'(floor_pos);
      outcome.entry_count = 9'(held_count);
      return outcome;
   endfunction

   // Follow register writes and input transfers
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         tolerance_now = '0;
      end else begin
         if (csr_wr_en) tolerance_now = csr_wr_data;
         if (start && !busy) due_outcomes.push_back(apply_to_table(req_data));
      end
   end

   task automatic note_mismatch(input string field, input int want, input int got);
      error_count++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (due_outcomes.size() == 0) begin
            note_mismatch("unexpected result, floor_index", 0, $signed(rsp_data.floor_index));
         end else begin
            want = due_outcomes.pop_front();
            if (rsp_data.floor_index !== want.floor_index)
               note_mismatch("floor_index", $signed(want.floor_index),
                             $signed(rsp_data.floor_index));
            if (rsp_data.entry_count !== want.entry_count)
               note_mismatch("entry_count", want.entry_count, rsp_data.entry_count);
            if (rsp_data.inserted !== want.inserted)
               note_mismatch("inserted", want.inserted, rsp_data.inserted);
            if (rsp_data.table_full !== want.table_full)
               note_mismatch("table_full", want.table_full, rsp_data.table_full);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offer one item, hold it until the transfer, then idle at random
   task automatic send_item(input logic mode, input logic signed [TIME_W-1:0] t);
      req_type item;
      int      gap;
      item.mode       = mode;
      item.time_value = t;
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      gap = 0;
      while (gap < 24 && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start and wait until every expected result has come back
   task automatic wait_results();
      int waited;
      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (due_outcomes.size() != 0 && waited < 400) begin
         @(posedge clock);
         waited++;
      end
      if (due_outcomes.size() != 0) begin
         error_count++;
         $display("%0t ns: %0d results never arrived", $time, due_outcomes.size());
         due_outcomes.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_tolerance(input logic [TOL_W-1:0] value);
      wait_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly times on or around held entries, so tolerance and neighbors matter
   function automatic logic signed [TIME_W-1:0] pick_time();
      logic signed [TIME_W-1:0] base;
      int                       kind;
      int                       offset;
      kind = $urandom_range(0, 99);
      if (held_count == 0 || kind < 35) return {$urandom, $urandom};
      base = held_times[$urandom_range(0, held_count - 1)];
      if (kind < 50) return base;
      if (kind < 80) begin
         case ($urandom_range(0, 3))
            0: return base + $signed({32'd0, tolerance_now});
            1: return base + $signed({32'd0, tolerance_now}) + 1;
            2: return base - $signed({32'd0, tolerance_now});
            default: return base - $signed({32'd0, tolerance_now}) - 1;
         endcase
      end
      if (kind < 90) begin
         offset = int'($urandom_range(0, 2000)) - 1000;
         return base + offset;
      end
      case ($urandom_range(0, 3))
         0: return TIME_MIN;
         1: return TIME_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // Empty table, extremes of time, exact duplicate
   task automatic test_empty_and_extremes();
      idle_pct = 0;
      send_item(MODE_LOOKUP, TIME_MIN);
      send_item(MODE_LOOKUP, 64'sd0);
      send_item(MODE_INSERT, 64'sd100);
      send_item(MODE_INSERT, 64'sd100);
      send_item(MODE_LOOKUP, 64'sd99);
      send_item(MODE_LOOKUP, 64'sd100);
      send_item(MODE_LOOKUP, TIME_MAX);
      send_item(MODE_INSERT, TIME_MIN);
      send_item(MODE_INSERT, TIME_MAX);
      send_item(MODE_LOOKUP, TIME_MIN);
      send_item(MODE_LOOKUP, TIME_MAX);
      send_item(MODE_INSERT, 64'sd101);
   endtask

   // Near matches through the floor entry and through the entry after it
   task automatic test_tolerance_edges();
      set_tolerance(32'd5);
      send_item(MODE_INSERT, 64'sd106);
      send_item(MODE_INSERT, 64'sd95);
      send_item(MODE_INSERT, 64'sd94);
      send_item(MODE_INSERT, 64'sd107);
      set_tolerance(32'hFFFF_FFFF);
      send_item(MODE_INSERT, 64'sd107 + 64'sh0000_0000_FFFF_FFFF);
      send_item(MODE_INSERT, 64'sd107 + 64'sh0000_0001_0000_0000);
      send_item(MODE_INSERT, TIME_MAX - 1);
      send_item(MODE_LOOKUP, TIME_MAX - 1);
      send_item(MODE_LOOKUP, 64'sd93);
   endtask

   // Random mix of lookups and inserts at one tolerance and idle rate
   task automatic run_random_mix(input int count, input int idle, input logic [TOL_W-1:0] tol);
      set_tolerance(tol);
      idle_pct = idle;
      repeat (count)
         send_item(($urandom_range(0, 99) < 50) ? MODE_INSERT : MODE_LOOKUP, pick_time());
   endtask

   task automatic test_random_mix();
      run_random_mix(115, 0, 32'd0);
      run_random_mix(115, 59, 32'hFFFF_FFFF);
      run_random_mix(115, 9, $urandom_range(0, 1000));
      run_random_mix(115, 59, $urandom);
   endtask

   // Fill the table, then drive dropped inserts and near matches into it
   task automatic test_full_table();
      set_tolerance(32'd0);
      idle_pct = 9;
      while (held_count < TABLE_DEPTH) send_item(MODE_INSERT, {$urandom, $urandom});
      run_random_mix(60, 9, $urandom_range(0, 100));
   endtask

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_extremes();
      test_tolerance_edges();
      test_random_mix();
      test_full_table();

      wait_results();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
